/* sv/tsit_pkg.sv */
// Shared types, constants and op codes of the transaction timestamp interval table.
package tsit_pkg;

  localparam int unsigned ID_W          = 31;
  localparam int unsigned OP_W          = 4;
  localparam int unsigned SLOT_W        = 4;
  localparam int unsigned SLOTS_DEFAULT = 16;

  localparam logic [ID_W-1:0] ID_ZERO = '0;
  localparam logic [ID_W-1:0] ID_MAX  = '1;

  typedef enum logic [OP_W-1:0] {
    OP_CONFLICT    = 4'd0,
    OP_SHRINK_MAX  = 4'd1,
    OP_RAISE_CMIN  = 4'd2,
    OP_AT_READ     = 4'd3,
    OP_READ        = 4'd4,
    OP_CLEAR       = 4'd5,
    OP_ACTIVE      = 4'd6,
    OP_FORCE_MAX   = 4'd7,
    OP_MVCC        = 4'd8,
    OP_ABORT       = 4'd9,
    OP_BEGIN       = 4'd10,
    OP_COMMIT_MARK = 4'd11
  } op_e;

  typedef struct packed {
    logic [ID_W-1:0] owner_tid;
    logic [ID_W-1:0] start_min;
    logic [ID_W-1:0] start_max;
    logic [ID_W-1:0] commit_min;
    logic [ID_W-1:0] commit_val;
    logic            done_mark;
  } entry_t;

  localparam entry_t ENTRY_CLEARED = '{
    owner_tid:  ID_ZERO,
    start_min:  ID_ZERO,
    start_max:  ID_MAX,
    commit_min: ID_ZERO,
    commit_val: ID_ZERO,
    done_mark:  1'b0
  };

  typedef struct packed {
    logic            flag;
    logic            commit_known;
    logic [ID_W-1:0] commit_id;
  } status_t;

endpackage

/* sv/tsit_mem.sv */
// Slot memory with registered read port and per-slot valid bits.
module tsit_mem import tsit_pkg::*; #(
  parameter int unsigned SLOTS = SLOTS_DEFAULT,
  parameter int unsigned IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_en_i,
  input  logic [IDX_W-1:0] wr_idx_i,
  input  entry_t           wr_data_i,
  input  logic             rd_en_i,
  input  logic [IDX_W-1:0] rd_idx_i,
  output entry_t           rd_data_o
);

  entry_t           mem_q [SLOTS];
  logic [SLOTS-1:0] valid_q;
  entry_t           rd_q;
  logic             rd_valid_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_idx_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q <= mem_q[rd_idx_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        valid_q[wr_idx_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_valid_q <= valid_q[rd_idx_i];
      end
    end
  end

  // A slot never written since reset reads as the cleared entry.
  assign rd_data_o = rd_valid_q ? rd_q : ENTRY_CLEARED;

endmodule

/* sv/tsit_alu.sv */
// Per-op update of one slot entry and the status that goes with the result.
module tsit_alu import tsit_pkg::*; (
  input  logic [OP_W-1:0] op_i,
  input  entry_t          cur_i,
  input  logic [ID_W-1:0] id_a_i,
  input  logic [ID_W-1:0] id_b_i,
  input  logic [ID_W-1:0] txn_id_i,
  output entry_t          nxt_o,
  output status_t         status_o
);

  logic [ID_W-1:0] a_dec;
  logic [ID_W-1:0] smin_mvcc;
  logic            flag;
  logic            known;
  entry_t          nxt;

  assign a_dec     = id_a_i - ID_W'(1);
  assign smin_mvcc = (cur_i.start_min < id_a_i) ? id_a_i : cur_i.start_min;

  always_comb begin
    nxt   = cur_i;
    flag  = 1'b1;
    known = 1'b0;
    unique case (op_e'(op_i))
      OP_CONFLICT: begin
        flag = (id_a_i > cur_i.start_min) ? 1'b0 : 1'b1;
      end
      OP_SHRINK_MAX: begin
        if (id_a_i > cur_i.start_min) begin
          if (a_dec < cur_i.start_max) begin
            nxt.start_max = a_dec;
          end
        end else begin
          flag = 1'b0;
        end
      end
      OP_RAISE_CMIN: begin
        if (id_a_i > cur_i.commit_min) begin
          nxt.commit_min = id_a_i;
        end
      end
      OP_AT_READ: begin
        nxt.start_min = id_a_i;
        if (cur_i.commit_min < id_a_i) begin
          nxt.commit_min = id_a_i;
        end
      end
      OP_READ: begin
        known = cur_i.done_mark;
      end
      OP_CLEAR: begin
        nxt = ENTRY_CLEARED;
      end
      OP_ACTIVE: begin
        // An owner of zero marks an empty slot, so a zero id never matches.
        if (txn_id_i != ID_ZERO && cur_i.owner_tid == txn_id_i) begin
          known = cur_i.done_mark;
        end else begin
          flag = 1'b0;
        end
      end
      OP_FORCE_MAX: begin
        if (cur_i.start_min >= id_a_i) begin
          flag = 1'b0;
        end else if (cur_i.start_max > id_a_i) begin
          nxt.start_max = id_a_i;
        end
      end
      OP_MVCC: begin
        nxt.start_min = smin_mvcc;
        if (cur_i.commit_min < id_b_i) begin
          nxt.commit_min = id_b_i;
        end
        flag = (smin_mvcc > cur_i.start_max) ? 1'b0 : 1'b1;
      end
      OP_ABORT: begin
        nxt.owner_tid = ID_ZERO;
      end
      OP_BEGIN: begin
        nxt.owner_tid = txn_id_i;
      end
      OP_COMMIT_MARK: begin
        nxt.commit_val = id_a_i;
        nxt.done_mark  = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign nxt_o                 = nxt;
  assign status_o.flag         = flag;
  assign status_o.commit_known = known;
  assign status_o.commit_id    = known ? nxt.commit_val : ID_ZERO;

endmodule

/* sv/txn_timestamp_interval_table_unit.sv */
// Top level of the transaction timestamp interval table.
//
// Input channel (in_valid_i / in_stall_o): one beat carries op, slot and three
// ids. Output channel (out_valid_o / out_stall_i): exactly one beat per input
// beat, in order, giving the flag, the completion status and the slot's
// interval as it stands after the operation.
// Each beat reads its slot from the slot memory at acceptance; from the update
// stage it is then updated, written back and placed in the output register.
// One beat per cycle is sustained while the receiver does not stall; a write
// to the same slot made as the beat is read is forwarded from
// a bypass register, since the memory read then still returns old data.
// When the receiver stalls, the output register holds its beat and the
// update stage holds the next one; a further input beat is stalled until the
// output register frees up. Slots at or above SLOTS change nothing and return
// all-zero beats.
// Reset empties both stages and marks every slot as cleared at once; the
// block takes beats as soon as reset is released.
module txn_timestamp_interval_table_unit import tsit_pkg::*; #(
  parameter int unsigned SLOTS = SLOTS_DEFAULT
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [OP_W-1:0]   op_i,
  input  logic [SLOT_W-1:0] slot_i,
  input  logic [ID_W-1:0]   id_a_i,
  input  logic [ID_W-1:0]   id_b_i,
  input  logic [ID_W-1:0]   txn_id_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic              flag_o,
  output logic              commit_known_o,
  output logic [ID_W-1:0]   start_min_out_o,
  output logic [ID_W-1:0]   start_max_out_o,
  output logic [ID_W-1:0]   commit_min_out_o,
  output logic [ID_W-1:0]   commit_id_out_o
);

  localparam int unsigned IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  logic             accept;
  logic             advance;
  logic             in_range;
  logic [IDX_W-1:0] in_idx;

  logic             s1_valid_q;
  logic             s1_in_range_q;
  logic [IDX_W-1:0] s1_idx_q;
  logic [OP_W-1:0]  s1_op_q;
  logic [ID_W-1:0]  s1_id_a_q;
  logic [ID_W-1:0]  s1_id_b_q;
  logic [ID_W-1:0]  s1_txn_id_q;

  logic             byp_valid_q;
  logic [IDX_W-1:0] byp_idx_q;
  entry_t           byp_entry_q;

  entry_t           rd_entry;
  entry_t           cur_entry;
  entry_t           nxt_entry;
  status_t          status;

  logic             out_valid_q;
  logic             out_valid_d;
  logic             flag_q;
  logic             known_q;
  logic [ID_W-1:0]  smin_q;
  logic [ID_W-1:0]  smax_q;
  logic [ID_W-1:0]  cmin_q;
  logic [ID_W-1:0]  cid_q;

  assign advance    = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !advance;
  assign accept     = in_valid_i && !in_stall_o;
  assign in_range   = (32'(slot_i) < SLOTS);
  assign in_idx     = IDX_W'(slot_i);

  tsit_mem #(
    .SLOTS (SLOTS),
    .IDX_W (IDX_W)
  ) u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (advance && s1_in_range_q),
    .wr_idx_i  (s1_idx_q),
    .wr_data_i (nxt_entry),
    .rd_en_i   (accept),
    .rd_idx_i  (in_idx),
    .rd_data_o (rd_entry)
  );

  // The memory read issued alongside a write to the same slot returns stale data.
  assign cur_entry = (byp_valid_q && byp_idx_q == s1_idx_q) ? byp_entry_q : rd_entry;

  tsit_alu u_alu (
    .op_i     (s1_op_q),
    .cur_i    (cur_entry),
    .id_a_i   (s1_id_a_q),
    .id_b_i   (s1_id_b_q),
    .txn_id_i (s1_txn_id_q),
    .nxt_o    (nxt_entry),
    .status_o (status)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      byp_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (advance) begin
        s1_valid_q <= 1'b0;
      end
      if (advance && s1_in_range_q) begin
        byp_valid_q <= 1'b1;
      end
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_in_range_q <= in_range;
      s1_idx_q      <= in_idx;
      s1_op_q       <= op_i;
      s1_id_a_q     <= id_a_i;
      s1_id_b_q     <= id_b_i;
      s1_txn_id_q   <= txn_id_i;
    end
    if (advance && s1_in_range_q) begin
      byp_idx_q   <= s1_idx_q;
      byp_entry_q <= nxt_entry;
    end
    if (advance) begin
      if (s1_in_range_q) begin
        flag_q  <= status.flag;
        known_q <= status.commit_known;
        smin_q  <= nxt_entry.start_min;
        smax_q  <= nxt_entry.start_max;
        cmin_q  <= nxt_entry.commit_min;
        cid_q   <= status.commit_id;
      end else begin
        flag_q  <= 1'b0;
        known_q <= 1'b0;
        smin_q  <= ID_ZERO;
        smax_q  <= ID_ZERO;
        cmin_q  <= ID_ZERO;
        cid_q   <= ID_ZERO;
      end
    end
  end

  assign out_valid_o      = out_valid_q;
  assign flag_o           = flag_q;
  assign commit_known_o   = known_q;
  assign start_min_out_o  = smin_q;
  assign start_max_out_o  = smax_q;
  assign commit_min_out_o = cmin_q;
  assign commit_id_out_o  = cid_q;

endmodule
